/* rtl/core/cwe_pkg.sv */
// Shared constants, types and fixed-point helpers of the circling wind estimator.
`timescale 1ns / 1ps
package cwe_pkg;

  localparam int SECTORS   = 8;
  localparam int IDX_W     = $clog2(SECTORS);
  localparam int SECTOR_W  = 360 / SECTORS;
  localparam int HALF_S    = SECTORS / 2;

  localparam int KNOTS_W   = 16;
  localparam int HEAD_W    = 16;
  localparam int TIME_W    = 32;
  localparam int SPEED_W   = 16;
  localparam int WIND_W    = 15;
  localparam int CNT_W     = 8;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 80;

  // speed_cms = (knots * 1852 + 1800) / 3600, the /3600 done as >>4 then /225
  localparam int SPD_MUL_W  = 11;
  localparam int SPD_PROD_W = 27;
  localparam logic [SPD_MUL_W-1:0] SPD_MUL   = 11'd1852;
  localparam logic [SPD_PROD_W-1:0] SPD_ROUND = 27'd1800;
  localparam int SPD_RECIP_W = 24;
  localparam int SPD_SHIFT   = 31;
  localparam logic [SPD_RECIP_W-1:0] SPD_RECIP = 24'd9544372;   // ceil(2^31 / 225)
  localparam int SPD_Q_W     = SPD_PROD_W - 4 + SPD_RECIP_W;

  // deg = cdeg / 100, done as >>2 then /25
  localparam int DEG_RECIP_W = 15;
  localparam int DEG_SHIFT   = 19;
  localparam logic [DEG_RECIP_W-1:0] DEG_RECIP = 15'd20972;     // ceil(2^19 / 25)
  localparam int DEG_PROD_W  = HEAD_W - 2 + DEG_RECIP_W;
  localparam int DEG_W       = 10;

  // sector = wrapped_deg / SECTOR_W
  localparam int WRAP_W      = 9;
  localparam int SEC_SHIFT   = 16;
  localparam int SEC_RECIP_W = 17;
  localparam logic [SEC_RECIP_W-1:0] SEC_RECIP =
    SEC_RECIP_W'((2 ** SEC_SHIFT + SECTOR_W - 1) / SECTOR_W);
  localparam int SEC_PROD_W  = WRAP_W + SEC_RECIP_W;
  localparam int SEC_RAW_W   = SEC_PROD_W - SEC_SHIFT;

  localparam logic signed [CNT_W-1:0] CNT_MAX  = 8'sd127;
  localparam logic signed [CNT_W-1:0] CNT_MIN  = -8'sd127;
  localparam logic signed [CNT_W-1:0] CNT_SECT = CNT_W'(SECTORS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_STEP,
    ST_CHECK,
    ST_SCAN,
    ST_SCAN_END,
    ST_FETCH_ADDR,
    ST_FETCH_DATA,
    ST_DONE
  } cwe_state_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic mul3;
    logic step;
    logic scan_clr;
    logic scan_rd;
    logic fetch_rd;
    logic fetch_latch;
    logic emit;
  } cwe_cmd_t;

  typedef struct packed {
    logic scan_needed;
    logic scan_last;
    logic out_busy;
  } cwe_status_t;

endpackage

/* rtl/core/cwe_ctrl.sv */
// Sequencer that steps one fix through conversion, sector update, scan (when needed) and output.
`timescale 1ns / 1ps
module cwe_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  cwe_pkg::cwe_status_t status,
  output cwe_pkg::cwe_cmd_t    cmd
);
  import cwe_pkg::*;

  cwe_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:       if (in_tvalid) state_nxt = ST_MUL1;
      ST_MUL1:       state_nxt = ST_MUL2;
      ST_MUL2:       state_nxt = ST_MUL3;
      ST_MUL3:       state_nxt = ST_STEP;
      ST_STEP:       state_nxt = ST_CHECK;
      ST_CHECK:      state_nxt = status.scan_needed ? ST_SCAN : ST_DONE;
      ST_SCAN:       if (status.scan_last) state_nxt = ST_SCAN_END;
      ST_SCAN_END:   state_nxt = ST_FETCH_ADDR;
      ST_FETCH_ADDR: state_nxt = ST_FETCH_DATA;
      ST_FETCH_DATA: state_nxt = ST_DONE;
      ST_DONE:       if (!status.out_busy) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    in_tready   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_MUL1:       cmd.mul1        = 1'b1;
      ST_MUL2:       cmd.mul2        = 1'b1;
      ST_MUL3:       cmd.mul3        = 1'b1;
      ST_STEP:       cmd.step        = 1'b1;
      ST_CHECK:      cmd.scan_clr    = 1'b1;
      ST_SCAN:       cmd.scan_rd     = 1'b1;
      ST_SCAN_END:   cmd             = '0;
      ST_FETCH_ADDR: cmd.fetch_rd    = 1'b1;
      ST_FETCH_DATA: cmd.fetch_latch = 1'b1;
      ST_DONE:       cmd.emit        = !status.out_busy;
      default:       cmd             = '0;
    endcase
  end

endmodule

/* rtl/core/cwe_datapath.sv */
// Fixed-point conversion, sector store, run counter, min/max scan and output register.
`timescale 1ns / 1ps
module cwe_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cwe_pkg::cwe_cmd_t                 cmd,
  output cwe_pkg::cwe_status_t              status,
  input  logic [cwe_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cwe_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import cwe_pkg::*;

  // latched fix
  logic [KNOTS_W-1:0]     knots_r;
  logic [HEAD_W-1:0]      heading_r;
  logic [TIME_W-1:0]      time_r;

  // conversion pipeline
  logic [SPD_PROD_W-1:0]  spd_prod_r;
  logic [DEG_PROD_W-1:0]  deg_prod_r;
  logic [SPD_Q_W-1:0]     spd_q_r;
  logic [WRAP_W-1:0]      wrap_r;
  logic [IDX_W-1:0]       sector_r;

  logic [DEG_W:0]         deg_half;
  logic [SEC_PROD_W-1:0]  sec_prod;
  logic [SEC_RAW_W-1:0]   sec_raw;
  logic [SPEED_W-1:0]     speed_cms;

  // run counter
  logic signed [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0]        prev_r;
  logic [IDX_W-1:0]        after_prev, after_sector;

  // sector store: {heading, speed} per sector
  logic [HEAD_W+SPEED_W-1:0] mem [SECTORS];
  logic [SECTORS-1:0]        valid_r;
  logic [HEAD_W+SPEED_W-1:0] rd_data_r;
  logic                      rd_ok_r;
  logic [IDX_W-1:0]          rd_addr;
  logic [SPEED_W-1:0]        rd_speed;
  logic [HEAD_W-1:0]         rd_head;

  // scan
  logic [IDX_W-1:0]       idx_r;
  logic [IDX_W-1:0]       cmp_idx_r;
  logic                   cmp_pend_r;
  logic [SPEED_W-1:0]     min_v_r, max_v_r;
  logic [IDX_W-1:0]       imin_r, imax_r;
  logic [IDX_W-1:0]       idx_diff;
  logic [IDX_W:0]         diff_ext;
  logic                   opposite;
  logic [SPEED_W-1:0]     span;

  // estimate
  logic [WIND_W-1:0]      est_speed_r;
  logic [HEAD_W-1:0]      est_dir_r;
  logic                   est_valid_r;
  logic [TIME_W-1:0]      est_time_r;
  logic                   updated_r;

  // output register
  logic                   out_valid_r;
  logic [WIND_W-1:0]      o_speed_r;
  logic [HEAD_W-1:0]      o_dir_r;
  logic                   o_valid_r;
  logic                   o_updated_r;
  logic [TIME_W-1:0]      o_time_r;
  logic [CNT_W-1:0]       o_count_r;

  // ---------------- conversion ----------------
  assign deg_half  = (DEG_W + 1)'(deg_prod_r[DEG_PROD_W-1:DEG_SHIFT]) +
                     (DEG_W + 1)'(SECTOR_W / 2);
  assign sec_prod  = SEC_PROD_W'(wrap_r) * SEC_PROD_W'(SEC_RECIP);
  assign sec_raw   = sec_prod[SEC_PROD_W-1:SEC_SHIFT];
  assign speed_cms = spd_q_r[SPD_SHIFT +: SPEED_W];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      knots_r   <= in_tdata[15:0];
      heading_r <= in_tdata[31:16];
      time_r    <= in_tdata[63:32];
    end
    if (cmd.mul1) begin
      spd_prod_r <= SPD_PROD_W'(knots_r) * SPD_PROD_W'(SPD_MUL) + SPD_ROUND;
      deg_prod_r <= DEG_PROD_W'(heading_r[HEAD_W-1:2]) * DEG_PROD_W'(DEG_RECIP);
    end
    if (cmd.mul2) begin
      spd_q_r <= SPD_Q_W'(spd_prod_r[SPD_PROD_W-1:4]) * SPD_Q_W'(SPD_RECIP);
      // deg + W/2 stays below 720, so one subtract folds it mod 360
      wrap_r  <= (deg_half >= (DEG_W + 1)'(360)) ? WRAP_W'(deg_half - (DEG_W + 1)'(360))
                                                  : WRAP_W'(deg_half);
    end
    if (cmd.mul3) begin
      // last sector absorbs the leftover when SECTORS does not divide 360
      sector_r <= (sec_raw > SEC_RAW_W'(SECTORS - 1)) ? IDX_W'(SECTORS - 1)
                                                      : IDX_W'(sec_raw);
    end
  end

  // ---------------- run counter ----------------
  assign after_prev   = (prev_r   == IDX_W'(SECTORS - 1)) ? '0 : prev_r + 1'b1;
  assign after_sector = (sector_r == IDX_W'(SECTORS - 1)) ? '0 : sector_r + 1'b1;

  always_comb begin
    count_nxt = count_r;
    priority if (sector_r == after_prev) begin
      if (!count_r[CNT_W-1]) begin
        if (count_r < CNT_MAX) count_nxt = count_r + 8'sd1;
      end else begin
        count_nxt = '0;
      end
    end else if (prev_r == after_sector) begin
      if (count_r <= 8'sd0) begin
        if (count_r > CNT_MIN) count_nxt = count_r - 8'sd1;
      end else begin
        count_nxt = '0;
      end
    end else if (prev_r != sector_r) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      prev_r  <= '0;
    end else if (cmd.step) begin
      count_r <= count_nxt;
      prev_r  <= sector_r;
    end
  end

  // ---------------- sector store ----------------
  assign rd_addr  = cmd.fetch_rd ? imin_r : idx_r;
  assign rd_speed = rd_ok_r ? rd_data_r[SPEED_W-1:0] : '0;
  assign rd_head  = rd_ok_r ? rd_data_r[HEAD_W+SPEED_W-1:SPEED_W] : '0;

  always_ff @(posedge clk) begin
    if (cmd.step) mem[sector_r] <= {heading_r, speed_cms};
    if (cmd.scan_rd || cmd.fetch_rd) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (cmd.step) valid_r[sector_r] <= 1'b1;
      if (cmd.scan_rd || cmd.fetch_rd) rd_ok_r <= valid_r[rd_addr];
    end
  end

  // ---------------- min/max scan ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      cmp_pend_r <= 1'b0;
    end else begin
      if (cmd.scan_clr) idx_r <= '0;
      else if (cmd.scan_rd) idx_r <= idx_r + 1'b1;
      cmp_pend_r <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) cmp_idx_r <= idx_r;
    if (cmp_pend_r) begin
      if (cmp_idx_r == '0) begin
        min_v_r <= rd_speed;
        max_v_r <= rd_speed;
        imin_r  <= '0;
        imax_r  <= '0;
      end else begin
        // strict compares keep the lowest index on ties
        if (rd_speed > max_v_r) begin
          max_v_r <= rd_speed;
          imax_r  <= cmp_idx_r;
        end
        if (rd_speed < min_v_r) begin
          min_v_r <= rd_speed;
          imin_r  <= cmp_idx_r;
        end
      end
    end
  end

  assign idx_diff = (imax_r > imin_r) ? imax_r - imin_r : imin_r - imax_r;
  assign diff_ext = {1'b0, idx_diff};
  assign opposite = (diff_ext + 1'b1 >= (IDX_W + 1)'(HALF_S)) &&
                    (diff_ext <= (IDX_W + 1)'(HALF_S + 1));
  assign span     = max_v_r - min_v_r;

  // ---------------- estimate ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_speed_r <= '0;
      est_dir_r   <= '0;
      est_valid_r <= 1'b0;
      est_time_r  <= '0;
      updated_r   <= 1'b0;
    end else begin
      if (cmd.load) updated_r <= 1'b0;
      if (cmd.fetch_latch && opposite) begin
        est_speed_r <= span[SPEED_W-1:1];
        est_dir_r   <= rd_head;
        est_valid_r <= 1'b1;
        est_time_r  <= time_r;
        updated_r   <= 1'b1;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_speed_r   <= est_speed_r;
      o_dir_r     <= est_dir_r;
      o_valid_r   <= est_valid_r;
      o_updated_r <= updated_r;
      o_time_r    <= est_time_r;
      o_count_r   <= count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, o_count_r, o_time_r, o_updated_r, o_valid_r, o_dir_r, o_speed_r};

  assign status.scan_needed = (count_r >= CNT_SECT) || (count_r <= -CNT_SECT);
  assign status.scan_last   = (idx_r == IDX_W'(SECTORS - 1));
  assign status.out_busy    = out_valid_r && !out_tready;

`ifndef SYNTHESIS
  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("beat not presented after emit");

  a_no_emit_over_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && !out_tready))
    else $error("output register overwritten while stalled");

  a_estimate_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    est_valid_r |=> est_valid_r)
    else $error("estimate valid dropped");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> (count_r != $past(count_r) || count_r != -8'sd128) && count_r != -8'sd128)
    else $error("run counter left its range");

  a_updated_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
    updated_r |-> est_valid_r)
    else $error("update flagged without an estimate");
`endif

endmodule

/* rtl/core/circling_wind_estimator_core.sv */
// Top level of the circling wind estimator: sequencer plus datapath.
//
// Usage:
//   in_*  : one GPS fix per beat; accepted when in_tvalid and in_tready are high.
//   out_* : exactly one result beat per fix, in fix order.
//   After accept a fix steps through MUL1, MUL2, MUL3, STEP and CHECK. With no
//   scan due CHECK goes to DONE; when the run counter magnitude has reached
//   SECTORS it runs the scan, then SCAN_END, FETCH_ADDR and FETCH_DATA before DONE.
//   DONE emits the result once the output register is free. The scan reads the
//   sector store one entry per cycle through its single read port. The sequencer
//   takes one fix at a time; in_tready is high only while the sequencer is idle.
//   The result sits in an output register, so the next fix is accepted while a
//   result waits; if out_tready stays low the sequencer holds its next result
//   in the datapath until the register frees up.
//   Reset (rst_n low, synchronous) clears the sector store valid bits, the run
//   counter, the previous sector and the latched estimate; stored sectors read
//   as zero until written.
`timescale 1ns / 1ps
module circling_wind_estimator_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [15:0] ground_speed_knots, [31:16] heading_cdeg, [63:32] time_ms
  input  logic [cwe_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [14:0] wind_speed_cms, [30:15] wind_dir_cdeg, [31] wind_valid,
  // [32] wind_updated, [64:33] valid_since_ms, [72:65] circle_count, [79:73] zero
  output logic [cwe_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import cwe_pkg::*;

  cwe_cmd_t    cmd;
  cwe_status_t status;

  cwe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  cwe_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
